FILE: src/prs_pkg.sv
package prs_pkg;

  // Field widths.
  localparam int unsigned WordW   = 32;
  localparam int unsigned RefineW = 4;
  localparam int unsigned SpaceW  = 31;
  localparam int unsigned DivW    = 2 * RefineW;

  // Largest refine factor that the register can encode.
  localparam int unsigned RefineCodeMax = (1 << RefineW) - 1;

  // Radix-16 divider: four quotient bits per cycle.
  localparam int unsigned DivBits  = 4;
  localparam int unsigned DivSteps = WordW / DivBits;

  // Depth of the job queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_REFINE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SPACING = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DOM_MIN = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_DOM_MAX = 2'd3;

  // Register reset values.
  localparam logic [RefineW-1:0] RefineReset  = 4'd2;
  localparam logic [SpaceW-1:0]  SpacingReset = 31'd65536;
  localparam logic [WordW-1:0]   DomMinReset  = 32'h0000_0000;
  localparam logic [WordW-1:0]   DomMaxReset  = 32'h7fff_ffff;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [RefineW-1:0]      refine;
    logic [SpaceW-1:0]       spacing;
    logic signed [WordW-1:0] dom_min;
    logic signed [WordW-1:0] dom_max;
  } cfg_t;

  // One validated mother, ready to be split.
  typedef struct packed {
    logic [WordW-1:0]        quot;
    logic [DivW-1:0]         rem;
    logic [DivW-1:0]         divisor;
    logic [RefineW-1:0]      refine;
    logic signed [WordW-1:0] first_pos;
    logic signed [WordW-1:0] vel_x;
    logic signed [WordW-1:0] vel_y;
    logic signed [WordW-1:0] vel_z;
  } job_t;

endpackage

FILE: src/prs_if.sv
// Mother particle channel.
interface prs_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] mother_weight;
  logic signed [31:0] mother_position;
  logic signed [31:0] vel_x_in;
  logic signed [31:0] vel_y_in;
  logic signed [31:0] vel_z_in;

  modport source (
    output valid, mother_weight, mother_position, vel_x_in, vel_y_in, vel_z_in,
    input  ready
  );
  modport sink (
    input  valid, mother_weight, mother_position, vel_x_in, vel_y_in, vel_z_in,
    output ready
  );
endinterface

// Child particle channel.
interface prs_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] child_weight;
  logic signed [31:0] child_position;
  logic signed [31:0] vel_x_out;
  logic signed [31:0] vel_y_out;
  logic signed [31:0] vel_z_out;
  logic               last_child;

  modport source (
    output valid, child_weight, child_position, vel_x_out, vel_y_out, vel_z_out,
           last_child,
    input  ready
  );
  modport sink (
    input  valid, child_weight, child_position, vel_x_out, vel_y_out, vel_z_out,
           last_child,
    output ready
  );
endinterface

FILE: src/prs_front.sv
module prs_front #(
  parameter int unsigned MAX_REFINE = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  prs_pkg::cfg_t  cfg_i,
  prs_in_if.sink         in_ch,
  output logic           push_o,
  output prs_pkg::job_t  job_o,
  input  logic           full_i
);
  import prs_pkg::*;

  localparam int unsigned RLim = (MAX_REFINE < RefineCodeMax) ? MAX_REFINE : RefineCodeMax;
  localparam int unsigned CntW = (DivSteps > 1) ? $clog2(DivSteps) : 1;
  localparam int unsigned OffW = RefineW + SpaceW;
  localparam int unsigned ChkW = OffW + 2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [RefineW-1:0]      refine_q;
  logic [DivW-1:0]         divisor_q;
  logic [OffW-1:0]         offset_q;
  logic signed [WordW-1:0] pos_q, first_q;
  logic signed [WordW-1:0] vx_q, vy_q, vz_q;
  logic [WordW-1:0]        dq_q, dq_d;
  logic [DivW-1:0]         drem_q, drem_d;

  logic                    accept;
  logic [RefineW-1:0]      refine_c;
  logic signed [ChkW-1:0]  first_c, last_c, lo_c, hi_c;
  logic                    in_domain;

  assign in_ch.ready = (state_q == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Clamp the refine factor to the supported range.
  always_comb begin
    if (cfg_i.refine == '0) begin
      refine_c = RefineW'(1);
    end else if (cfg_i.refine > RefineW'(RLim)) begin
      refine_c = RefineW'(RLim);
    end else begin
      refine_c = cfg_i.refine;
    end
  end

  // Outermost children, checked at full width against the open domain.
  always_comb begin
    first_c   = ChkW'(pos_q) - $signed({2'b00, offset_q});
    last_c    = ChkW'(pos_q) + $signed({2'b00, offset_q});
    lo_c      = ChkW'(cfg_i.dom_min);
    hi_c      = ChkW'(cfg_i.dom_max);
    in_domain = (first_c > lo_c) && (first_c < hi_c) && (last_c > lo_c) && (last_c < hi_c);
  end

  // Four restoring division steps per cycle, weight over r squared.
  always_comb begin
    logic [DivW:0]    t;
    logic [DivW-1:0]  r;
    logic [WordW-1:0] qv;
    r  = drem_q;
    qv = dq_q;
    for (int i = 0; i < DivBits; i++) begin
      t  = {r, qv[WordW-1]};
      qv = {qv[WordW-2:0], 1'b0};
      if (t >= {1'b0, divisor_q}) begin
        t     = t - {1'b0, divisor_q};
        qv[0] = 1'b1;
      end
      r = t[DivW-1:0];
    end
    drem_d = r;
    dq_d   = qv;
  end

  // Sequencer: accept, check (a mother outside the domain is dropped), divide, hand over.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CHECK;
      end
      S_CHECK: begin
        cnt_d   = '0;
        state_d = in_domain ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Mother payload and divider datapath.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      refine_q  <= refine_c;
      divisor_q <= DivW'(refine_c) * DivW'(refine_c);
      offset_q  <= OffW'(refine_c - RefineW'(1)) * OffW'(cfg_i.spacing);
      pos_q     <= in_ch.mother_position;
      vx_q      <= in_ch.vel_x_in;
      vy_q      <= in_ch.vel_y_in;
      vz_q      <= in_ch.vel_z_in;
      dq_q      <= in_ch.mother_weight;
      drem_q    <= '0;
    end else if (state_q == S_DIV) begin
      dq_q   <= dq_d;
      drem_q <= drem_d;
    end
    if (state_q == S_CHECK) begin
      first_q <= first_c[WordW-1:0];
    end
  end

  always_comb begin
    job_o.quot      = dq_q;
    job_o.rem       = drem_q;
    job_o.divisor   = divisor_q;
    job_o.refine    = refine_q;
    job_o.first_pos = first_q;
    job_o.vel_x     = vx_q;
    job_o.vel_y     = vy_q;
    job_o.vel_z     = vz_q;
  end

endmodule

FILE: src/prs_queue.sv
module prs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  prs_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output prs_pkg::job_t job_o,
  output logic          empty_o
);
  import prs_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

FILE: src/prs_back.sv
module prs_back #(
  parameter int unsigned MAX_REFINE = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [prs_pkg::SpaceW-1:0] spacing_i,
  input  prs_pkg::job_t              job_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  prs_out_if.source                  out_ch
);
  import prs_pkg::*;

  localparam int unsigned RLim = (MAX_REFINE < RefineCodeMax) ? MAX_REFINE : RefineCodeMax;
  localparam int unsigned KW   = $clog2(2 * RLim);

  logic                    valid_q;
  logic [KW-1:0]           k_q;
  logic [RefineW-1:0]      refine_q;
  logic [WordW-1:0]        quot_q, step_q;
  logic [DivW-1:0]         rem_q, step_rem_q, divisor_q;
  logic signed [WordW-1:0] pos_q, vx_q, vy_q, vz_q;

  logic                    take, last, load, rising;
  logic [KW-1:0]           k_peak, k_last;
  logic [DivW:0]           sum_rem, diff_rem;
  logic                    wrap, borrow;
  logic [WordW-1:0]        quot_n;
  logic [DivW-1:0]         rem_n;

  // Child k rises in weight up to the peak child r-1, then falls.
  assign k_peak = KW'(refine_q - RefineW'(1));
  assign k_last = KW'({refine_q - RefineW'(1), 1'b0});
  assign last   = (k_q == k_last);
  assign rising = (k_q < k_peak);

  assign take  = out_ch.valid && out_ch.ready;
  assign load  = !valid_q || (take && last);
  assign pop_o = load && !empty_i;

  // Next weight quotient: add or remove one mother weight over r squared.
  always_comb begin
    sum_rem  = {1'b0, rem_q} + {1'b0, step_rem_q};
    diff_rem = {1'b0, rem_q} - {1'b0, step_rem_q};
    wrap     = (sum_rem >= {1'b0, divisor_q});
    borrow   = diff_rem[DivW];
    if (rising) begin
      rem_n  = wrap ? DivW'(sum_rem - {1'b0, divisor_q}) : sum_rem[DivW-1:0];
      quot_n = quot_q + step_q + WordW'(wrap);
    end else begin
      rem_n  = borrow ? DivW'(diff_rem + {1'b0, divisor_q}) : diff_rem[DivW-1:0];
      quot_n = quot_q - step_q - WordW'(borrow);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      k_q     <= '0;
    end else if (load) begin
      valid_q <= 1'b0;
    end else if (take) begin
      k_q <= k_q + KW'(1);
    end
  end

  // Child payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      refine_q   <= job_i.refine;
      quot_q     <= job_i.quot;
      step_q     <= job_i.quot;
      rem_q      <= job_i.rem;
      step_rem_q <= job_i.rem;
      divisor_q  <= job_i.divisor;
      pos_q      <= job_i.first_pos;
      vx_q       <= job_i.vel_x;
      vy_q       <= job_i.vel_y;
      vz_q       <= job_i.vel_z;
    end else if (take && !last) begin
      quot_q <= quot_n;
      rem_q  <= rem_n;
      pos_q  <= pos_q + $signed({1'b0, spacing_i});
    end
  end

  assign out_ch.valid          = valid_q;
  assign out_ch.child_weight   = quot_q;
  assign out_ch.child_position = pos_q;
  assign out_ch.vel_x_out      = vx_q;
  assign out_ch.vel_y_out      = vy_q;
  assign out_ch.vel_z_out      = vz_q;
  assign out_ch.last_child     = last;

endmodule

FILE: src/particle_refinement_splitter.sv
// The front checks each accepted mother against the domain, then runs the
// radix-16 weight divider; the back sends one child per cycle while the
// output is ready, and a two-entry queue lets front and back overlap, so the
// front can take a new mother while the back still sends children.
// Reset: asynchronous, active low; registers return to their defaults and
// the queue and both sides go empty at once.
module particle_refinement_splitter #(
  parameter int unsigned MAX_REFINE = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  prs_in_if.sink      in_ch,
  prs_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import prs_pkg::*;

  cfg_t cfg_q;
  job_t front_job, queue_job;
  logic push, full, pop, empty;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.refine  <= RefineReset;
      cfg_q.spacing <= SpacingReset;
      cfg_q.dom_min <= DomMinReset;
      cfg_q.dom_max <= DomMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REFINE:  cfg_q.refine  <= cfg_data_i[RefineW-1:0];
        REG_SPACING: cfg_q.spacing <= cfg_data_i[SpaceW-1:0];
        REG_DOM_MIN: cfg_q.dom_min <= cfg_data_i;
        REG_DOM_MAX: cfg_q.dom_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  prs_front #(
    .MAX_REFINE (MAX_REFINE)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_ch  (in_ch),
    .push_o (push),
    .job_o  (front_job),
    .full_i (full)
  );

  prs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (queue_job),
    .empty_o (empty)
  );

  prs_back #(
    .MAX_REFINE (MAX_REFINE)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .spacing_i (cfg_q.spacing),
    .job_i     (queue_job),
    .empty_i   (empty),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/particle_refinement_splitter_tb.sv
module particle_refinement_splitter_tb;
  import prs_pkg::*;

  localparam int MaxRefine = 8;

  // One mother particle as offered on the input channel.
  typedef struct packed {
    logic        [31:0] weight;
    logic signed [31:0] pos;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } mother_t;

  // One child particle as expected on the output channel.
  typedef struct packed {
    logic        [31:0] weight;
    logic signed [31:0] pos;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               last;
  } child_t;

  // How a directed row is handled: a register write, or a mother whose children come
  // from the predictor, are known to be absent, or are the mother itself.
  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_NONE, ROW_SELF} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [31:0]         data;
    mother_t             m;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [31:0]       cfg_data_i;

  prs_in_if  in_ch ();
  prs_out_if out_ch ();

  particle_refinement_splitter #(
    .MAX_REFINE(MaxRefine)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the configuration registers.
  logic        [RefineW-1:0] cfg_refine  = RefineReset;
  logic        [SpaceW-1:0]  cfg_spacing = SpacingReset;
  logic signed [WordW-1:0]   cfg_lo      = DomMinReset;
  logic signed [WordW-1:0]   cfg_hi      = DomMaxReset;

  child_t pending_children [$];
  row_t   directed_rows [$];

  int src_idle_pct  = 0;
  int snk_idle_pct  = 0;
  int err_cnt       = 0;
  int mothers_sent  = 0;
  int children_seen = 0;
  int cfg_writes    = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Refine factor as the block applies it: zero acts as one, large values saturate.
  function automatic int eff_refine();
    int r;
    r = int'(cfg_refine);
    if (r < 1) r = 1;
    if (r > MaxRefine) r = MaxRefine;
    return r;
  endfunction

  // Work out the children of one mother and queue them in emission order.
  function automatic void split_mother(input mother_t m);
    int               r;
    int               n;
    int               tri_f;
    longint           sp;
    longint           lo;
    longint           hi;
    longint           first_pos;
    longint           last_pos;
    longint           cpos;
    logic [63:0]      cw;
    child_t           c;
    r         = eff_refine();
    n         = 2 * r - 1;
    sp        = longint'(cfg_spacing);
    lo        = longint'($signed(cfg_lo));
    hi        = longint'($signed(cfg_hi));
    first_pos = longint'($signed(m.pos)) - longint'(r - 1) * sp;
    last_pos  = longint'($signed(m.pos)) + longint'(r - 1) * sp;
    // Both outermost children must lie strictly inside the domain.
    if (!(first_pos > lo && first_pos < hi && last_pos > lo && last_pos < hi)) return;
    for (int k = 0; k < n; k++) begin
      tri_f    = (k + 1 < n - k) ? k + 1 : n - k;
      cw       = {32'd0, m.weight} * 64'(tri_f) / 64'(r * r);
      cpos     = first_pos + longint'(k) * sp;
      c.weight = cw[31:0];
      c.pos    = cpos[31:0];
      c.vx     = m.vx;
      c.vy     = m.vy;
      c.vz     = m.vz;
      c.last   = (k == n - 1);
      pending_children = {pending_children, c};
    end
  endfunction

  // Directed table builders.
  function automatic void row_cfg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void row_item(input row_kind_e kind, input logic [31:0] w,
                                   input logic [31:0] p, input logic [31:0] vx,
                                   input logic [31:0] vy, input logic [31:0] vz);
    row_t row;
    row          = '0;
    row.kind     = kind;
    row.m.weight = w;
    row.m.pos    = p;
    row.m.vx     = vx;
    row.m.vy     = vy;
    row.m.vz     = vz;
    directed_rows = {directed_rows, row};
  endfunction

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_REFINE:  cfg_refine  = data[RefineW-1:0];
      REG_SPACING: cfg_spacing = data[SpaceW-1:0];
      REG_DOM_MIN: cfg_lo      = data;
      REG_DOM_MAX: cfg_hi      = data;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // Hold the sender until every expected child is out, then let the front finish
  // any mother that yields no children.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_children.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Offer one mother and record what it should produce once it is accepted.
  task automatic send_mother(input mother_t m, input row_kind_e kind);
    child_t c;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.mother_weight   <= m.weight;
    in_ch.mother_position <= m.pos;
    in_ch.vel_x_in        <= m.vx;
    in_ch.vel_y_in        <= m.vy;
    in_ch.vel_z_in        <= m.vz;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    mothers_sent++;
    case (kind)
      ROW_SELF: begin
        c = {m.weight, m.pos, m.vx, m.vy, m.vz, 1'b1};
        pending_children = {pending_children, c};
      end
      ROW_PREDICT: split_mother(m);
      default: ;
    endcase
  endtask

  // Random settings, from plain to hostile.
  task automatic shuffle_setup();
    logic [RefineW-1:0] r;
    logic [SpaceW-1:0]  sp;
    logic [31:0]        lo;
    logic [31:0]        hi;
    logic [31:0]        t;
    case ($urandom_range(0, 5))
      0:       r = 4'd0;
      1:       r = 4'd1;
      2:       r = 4'd8;
      3:       r = 4'($urandom_range(9, 15));
      default: r = 4'($urandom_range(2, 7));
    endcase
    case ($urandom_range(0, 4))
      0:       sp = '0;
      1:       sp = 31'($urandom);
      default: sp = 31'($urandom_range(1, 32'h0008_0000));
    endcase
    lo = $urandom;
    hi = $urandom;
    case ($urandom_range(0, 4))
      0: ;  // leave as drawn, possibly empty or inverted
      1: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      default: begin
        if ($signed(lo) > $signed(hi)) begin
          t  = lo;
          lo = hi;
          hi = t;
        end
      end
    endcase
    write_reg(REG_REFINE, {28'd0, r});
    write_reg(REG_SPACING, {1'b0, sp});
    write_reg(REG_DOM_MIN, lo);
    write_reg(REG_DOM_MAX, hi);
  endtask

  // Random mother; where the domain leaves room, most land where all their children fit inside it.
  function automatic mother_t rand_mother();
    mother_t        m;
    longint         span;
    longint         lo_ok;
    longint         hi_ok;
    longint         pos_l;
    logic [63:0]    rnd;
    case ($urandom_range(0, 7))
      0:       m.weight = '0;
      1:       m.weight = 32'hffff_ffff;
      2:       m.weight = $urandom_range(0, 255);
      default: m.weight = $urandom;
    endcase
    m.vx  = $urandom;
    m.vy  = $urandom;
    m.vz  = $urandom;
    m.pos = $urandom;
    span  = longint'(eff_refine() - 1) * longint'(cfg_spacing);
    lo_ok = longint'($signed(cfg_lo)) + span + 1;
    hi_ok = longint'($signed(cfg_hi)) - span - 1;
    if (lo_ok <= hi_ok && $urandom_range(0, 99) < 85) begin
      rnd   = {$urandom, $urandom};
      pos_l = lo_ok + longint'(rnd % 64'(hi_ok - lo_ok + 1));
      m.pos = pos_l[31:0];
    end
    return m;
  endfunction

  // Count and, for the first few, describe a failure.
  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("Child %0d, %s: expected %h, got %h", children_seen, name, want, got);
  endtask

  // Output side: random back-pressure and a field-by-field check of each word.
  always @(posedge clk_i) begin
    child_t got;
    child_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.child_weight, out_ch.child_position, out_ch.vel_x_out,
               out_ch.vel_y_out, out_ch.vel_z_out, out_ch.last_child};
        if (pending_children.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("Child word with nothing pending: weight %h position %h",
                     got.weight, got.pos);
        end else begin
          want = pending_children.pop_front();
          if (got.weight !== want.weight) report_field("child_weight", want.weight, got.weight);
          if (got.pos !== want.pos)    report_field("child_position", want.pos, got.pos);
          if (got.vx !== want.vx)      report_field("vel_x_out", want.vx, got.vx);
          if (got.vy !== want.vy)      report_field("vel_y_out", want.vy, got.vy);
          if (got.vz !== want.vz)      report_field("vel_z_out", want.vz, got.vz);
          if (got.last !== want.last)  report_field("last_child", 32'(want.last), 32'(got.last));
        end
        children_seen++;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Stimulus.
  initial begin
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= REG_REFINE;
    cfg_data_i            <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.mother_weight   <= '0;
    in_ch.mother_position <= '0;
    in_ch.vel_x_in        <= '0;
    in_ch.vel_y_in        <= '0;
    in_ch.vel_z_in        <= '0;

    // Reset settings: r = 2, spacing 1.0, domain (0, max).
    row_item(ROW_NONE,    32'h0004_0000, 32'h0000_0000, 32'h1, 32'h2, 32'h3);
    row_item(ROW_PREDICT, 32'h0004_0000, 32'h000a_0000, 32'h0001_0000, 32'hffff_0000, 32'h0);
    row_item(ROW_NONE,    32'h0004_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    row_item(ROW_PREDICT, 32'h0000_0003, 32'h0001_0001, 32'h5, 32'h6, 32'h7);
    row_item(ROW_NONE,    32'h0001_0000, 32'h7ffe_ffff, 32'h0, 32'h0, 32'h0);
    row_item(ROW_PREDICT, 32'hffff_ffff, 32'h7ffe_fffe, 32'h8000_0000, 32'h7fff_ffff,
             32'hffff_ffff);
    row_item(ROW_PREDICT, 32'h0000_0000, 32'h0064_0000, 32'h0, 32'hffff_ffff, 32'h1);
    row_item(ROW_NONE,    32'h0001_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    // Refine factor zero acts as one: each child is the mother itself.
    row_cfg(REG_REFINE, 32'd0);
    row_cfg(REG_DOM_MIN, 32'h8000_0000);
    row_item(ROW_NONE,    32'h0001_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    row_item(ROW_SELF,    32'hffff_ffff, 32'h8000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
    row_item(ROW_SELF,    32'h0000_0001, 32'h7fff_fffe, 32'hffff_ffff, 32'h0, 32'h8000_0000);
    row_item(ROW_SELF,    32'h0001_2345, 32'h0000_0000, 32'h1234_5678, 32'h9abc_def0,
             32'h0f0f_0f0f);
    // Saturated refine factor with zero spacing: all children share the position.
    row_cfg(REG_REFINE, 32'd15);
    row_cfg(REG_SPACING, 32'd0);
    row_item(ROW_PREDICT, 32'hffff_ffff, 32'h0000_0000, 32'h1, 32'h2, 32'h3);
    row_item(ROW_PREDICT, 32'h0000_0040, 32'h8000_0001, 32'h4, 32'h5, 32'h6);
    // Widest spacing throws the outer children beyond 32 bits.
    row_cfg(REG_SPACING, 32'h7fff_ffff);
    row_item(ROW_NONE,    32'h0001_0000, 32'h0000_0000, 32'h0, 32'h0, 32'h0);
    row_cfg(REG_REFINE, 32'd1);
    row_item(ROW_SELF,    32'h0002_0000, 32'h0000_0005, 32'h7, 32'h8, 32'h9);
    // Empty and inverted domains pass nothing.
    row_cfg(REG_DOM_MIN, 32'h0001_0000);
    row_cfg(REG_DOM_MAX, 32'h0001_0000);
    row_item(ROW_NONE,    32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    row_cfg(REG_DOM_MIN, 32'h7fff_ffff);
    row_cfg(REG_DOM_MAX, 32'h8000_0000);
    row_item(ROW_NONE,    32'h0001_0000, 32'h0000_0000, 32'h0, 32'h0, 32'h0);
    // Full domain, r = 8, finest spacing: outer children right at and next to the bounds.
    row_cfg(REG_REFINE, 32'd8);
    row_cfg(REG_SPACING, 32'd1);
    row_cfg(REG_DOM_MIN, 32'h8000_0000);
    row_cfg(REG_DOM_MAX, 32'h7fff_ffff);
    row_item(ROW_PREDICT, 32'h0040_0000, 32'h0000_0000, 32'h1, 32'h1, 32'h1);
    row_item(ROW_NONE,    32'h0001_0000, 32'h7fff_fff8, 32'h0, 32'h0, 32'h0);
    row_item(ROW_PREDICT, 32'hffff_ffff, 32'h7fff_fff7, 32'h2, 32'h2, 32'h2);
    row_item(ROW_NONE,    32'h0001_0000, 32'h8000_0007, 32'h0, 32'h0, 32'h0);
    row_item(ROW_PREDICT, 32'h0000_0040, 32'h8000_0008, 32'h3, 32'h3, 32'h3);
    row_cfg(REG_REFINE, 32'd9);
    row_item(ROW_PREDICT, 32'h0009_0000, 32'h0000_0000, 32'h4, 32'h4, 32'h4);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, moderate idling on both sides.
    src_idle_pct = 20;
    snk_idle_pct = 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_mother(directed_rows[i].m, directed_rows[i].kind);
      end
    end

    // Random part in three idling phases, each over several settings.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 35;
          snk_idle_pct = 55;
        end
        1: begin
          src_idle_pct = 55;
          snk_idle_pct = 35;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        wait_drained();
        shuffle_setup();
        for (int i = 0; i < 38; i++) begin
          // Now and then the sender stops until the output side has caught up.
          if ($urandom_range(0, 49) == 0) wait_drained();
          send_mother(rand_mother(), ROW_PREDICT);
        end
      end
    end

    wait_drained();
    $display("Split %0d mothers into %0d checked children over %0d register writes,",
             mothers_sent, children_seen, cfg_writes);
    $display("covering refine factors 0 to 15, bound hits and three idling patterns.");
    if (err_cnt == 0 && pending_children.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
